FILE: rtl/u2u8_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the UTF-8 byte encoder function for the
// UTF-16 / Latin-1 to UTF-8 transcoder. No dependencies.
package u2u8_pkg;

  localparam int UnitWidth   = 16;
  localparam int LenWidth    = 16;
  localparam int CpWidth     = 21;
  localparam int MaxBytes    = 6;
  localparam int CountWidth  = 3;

  localparam logic [UnitWidth-1:0] HIGH_FIRST = 16'hD800;
  localparam logic [UnitWidth-1:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [UnitWidth-1:0] LOW_FIRST  = 16'hDC00;
  localparam logic [UnitWidth-1:0] LOW_LAST   = 16'hDFFF;
  localparam logic [CpWidth-1:0]   CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CpWidth-1:0]   CP_SUPPLEMENTARY = 21'h010000;
  localparam logic [CpWidth-1:0]   CP_TWO_BYTE   = 21'h000080;
  localparam logic [CpWidth-1:0]   CP_THREE_BYTE = 21'h000800;
  localparam logic [LenWidth-1:0]  OUT_LIMIT_RESET = 16'd255;

  typedef struct packed {
    logic                 eos;
    logic [UnitWidth-1:0] code_unit;
    logic                 mode;
  } item_t;

  typedef struct packed {
    logic [3:0][7:0]       b;
    logic [CountWidth-1:0] n;
  } seq_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountWidth-1:0]    count;
    logic                     has_bytes;
    logic                     eos;
    logic [LenWidth-1:0]      length;
  } burst_t;

  function automatic seq_t encode_cp(input logic [CpWidth-1:0] cp);
    seq_t s;
    s = '0;
    if (cp < CP_TWO_BYTE) begin
      s.b[0] = cp[7:0];
      s.n    = 3'd1;
    end else if (cp < CP_THREE_BYTE) begin
      s.b[0] = {3'b110, cp[10:6]};
      s.b[1] = {2'b10, cp[5:0]};
      s.n    = 3'd2;
    end else if (cp < CP_SUPPLEMENTARY) begin
      s.b[0] = {4'b1110, cp[15:12]};
      s.b[1] = {2'b10, cp[11:6]};
      s.b[2] = {2'b10, cp[5:0]};
      s.n    = 3'd3;
    end else begin
      s.b[0] = {5'b11110, cp[20:18]};
      s.b[1] = {2'b10, cp[17:12]};
      s.b[2] = {2'b10, cp[11:6]};
      s.b[3] = {2'b10, cp[5:0]};
      s.n    = 3'd4;
    end
    return s;
  endfunction

endpackage

FILE: rtl/u2u8_unit_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries one input code unit per transaction.
// Depends on nothing.
interface u2u8_unit_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] code_unit;
  logic        end_of_string;

  modport source (output valid, mode, code_unit, end_of_string, input ready);
  modport sink (input valid, mode, code_unit, end_of_string, output ready);
endinterface

FILE: rtl/u2u8_byte_if.sv
`timescale 1ns / 1ps
// Valid/ready channel that carries one UTF-8 result byte per transaction.
// Depends on nothing.
interface u2u8_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last_of_item;
  logic        string_done;
  logic [15:0] string_length;

  modport source (output valid, out_byte, byte_valid, last_of_item, string_done,
                  string_length, input ready);
  modport sink (input valid, out_byte, byte_valid, last_of_item, string_done,
                string_length, output ready);
endinterface

FILE: rtl/utf16_latin1_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// Top level of the UTF-16 / Latin-1 to UTF-8 transcoder.
// Depends on u2u8_pkg, u2u8_unit_if, u2u8_byte_if, u2u8_in_reg,
// u2u8_encoder and u2u8_serializer.
//
// Usage: each transaction on the unit channel carries one code unit, either a
// Latin-1 byte (mode 0) or a UTF-16 code unit (mode 1), and end_of_string on
// the last unit of a string. Each transaction on the utf8 channel carries one
// UTF-8 byte; last_of_item marks the final result of a unit, and on an
// end-of-string unit string_done and string_length report the byte total. An
// end-of-string unit that emits nothing gives one result with byte_valid low.
// The byte budget per string is written through cfg_we and cfg_wdata while idle.
// The first byte of a unit passes through the input register and then the byte
// register. The byte register delivers one result per output transaction; a
// unit gives up to six bytes, four for a supplementary character. A new unit
// is taken while the last byte of the previous one is being delivered. When
// utf8.ready is low the byte register holds, the input register fills, and
// unit.ready drops. Reset empties both registers, clears the surrogate and
// string state and sets the budget to 255.
module utf16_latin1_to_utf8_transcoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [u2u8_pkg::LenWidth-1:0] cfg_wdata,
  u2u8_unit_if.sink                     unit,
  u2u8_byte_if.source                   utf8
);
  import u2u8_pkg::*;

  logic                item_valid;
  item_t               item;
  burst_t              burst;
  logic                free;
  logic                take;
  logic [LenWidth-1:0] out_limit;

  assign take = item_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= OUT_LIMIT_RESET;
    end else if (cfg_we) begin
      out_limit <= cfg_wdata;
    end
  end

  u2u8_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .unit       (unit),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  u2u8_encoder u_encoder (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (item),
    .out_limit (out_limit),
    .burst     (burst)
  );

  u2u8_serializer u_serializer (
    .clk   (clk),
    .rst   (rst),
    .burst (burst),
    .take  (take),
    .free  (free),
    .utf8  (utf8)
  );

  a_length_only_at_end: assert property (@(posedge clk) disable iff (rst)
    utf8.valid && !utf8.byte_valid |-> utf8.string_done && utf8.last_of_item)
    else $error("length-only result outside end of string");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> unit.ready)
    else $error("empty input register refuses a transaction");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !utf8.valid && !item_valid)
    else $error("registers not empty after reset");

  a_take_needs_room: assert property (@(posedge clk) disable iff (rst)
    take && utf8.valid |-> utf8.ready && utf8.last_of_item)
    else $error("burst loaded over undelivered bytes");
endmodule

FILE: rtl/u2u8_in_reg.sv
`timescale 1ns / 1ps
// Input register: captures one code unit transaction and holds it until
// the encoder takes it. Depends on u2u8_pkg and u2u8_unit_if.
module u2u8_in_reg (
  input  logic            clk,
  input  logic            rst,
  u2u8_unit_if.sink       unit,
  input  logic            take,
  output logic            item_valid,
  output u2u8_pkg::item_t item
);
  import u2u8_pkg::*;

  assign unit.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (unit.valid && unit.ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (unit.valid && unit.ready) begin
      item.mode      <= unit.mode;
      item.code_unit <= unit.code_unit;
      item.eos       <= unit.end_of_string;
    end
  end
endmodule

FILE: rtl/u2u8_encoder.sv
`timescale 1ns / 1ps
// Per-string transcoding state and the single-pass encoder that turns one
// code unit into a burst of up to six UTF-8 bytes. Depends on u2u8_pkg.
module u2u8_encoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  u2u8_pkg::item_t           item,
  input  logic [u2u8_pkg::LenWidth-1:0] out_limit,
  output u2u8_pkg::burst_t          burst
);
  import u2u8_pkg::*;

  logic                high_pending, high_pending_next;
  logic [9:0]          high_bits, high_bits_next;
  logic [LenWidth-1:0] bytes_written, bytes_written_next;
  logic                output_stopped, output_stopped_next;

  logic                is_low, is_high, pair;
  logic [CpWidth-1:0]  cp_a, cp_b;
  seq_t                seq_a, seq_b;
  logic                a_try, a_emit, a_fail, b_try, b_emit, b_fail, set_pending;
  logic [LenWidth:0]   sum_a, base_b, sum_b;
  logic [CountWidth-1:0] n_emit;

  always_comb begin
    is_low  = item.mode && item.code_unit >= LOW_FIRST && item.code_unit <= LOW_LAST;
    is_high = item.mode && item.code_unit >= HIGH_FIRST && item.code_unit <= HIGH_LAST;
    pair    = high_pending && is_low;

    cp_a  = pair ? CP_SUPPLEMENTARY + {1'b0, high_bits, 10'd0}
                   + {11'd0, item.code_unit[9:0]}
                 : CP_REPLACEMENT;
    seq_a = encode_cp(cp_a);
    sum_a = {1'b0, bytes_written} + {14'd0, seq_a.n};
    a_try = !output_stopped && high_pending;
    a_emit = a_try && (sum_a <= {1'b0, out_limit});
    a_fail = a_try && !a_emit;

    if (!item.mode) begin
      cp_b = {13'd0, item.code_unit[7:0]};
    end else if (is_high || is_low) begin
      cp_b = CP_REPLACEMENT;
    end else begin
      cp_b = {5'd0, item.code_unit};
    end
    seq_b  = encode_cp(cp_b);
    base_b = a_emit ? sum_a : {1'b0, bytes_written};
    sum_b  = base_b + {14'd0, seq_b.n};
    set_pending = !output_stopped && !pair && !a_fail && is_high && !item.eos;
    b_try  = !output_stopped && !pair && !a_fail && !(is_high && !item.eos);
    b_emit = b_try && (sum_b <= {1'b0, out_limit});
    b_fail = b_try && !b_emit;

    n_emit = (a_emit ? seq_a.n : 3'd0) + (b_emit ? seq_b.n : 3'd0);
    bytes_written_next = b_emit ? sum_b[LenWidth-1:0] : base_b[LenWidth-1:0];

    burst = '0;
    if (a_emit) begin
      burst.bytes[3:0] = seq_a.b;
    end
    if (b_emit) begin
      if (a_emit) begin
        burst.bytes[5:3] = seq_b.b[2:0];
      end else begin
        burst.bytes[3:0] = seq_b.b;
      end
    end
    burst.has_bytes = n_emit != 3'd0;
    burst.count     = (item.eos && n_emit == 3'd0) ? 3'd1 : n_emit;
    burst.eos       = item.eos;
    burst.length    = item.eos ? bytes_written_next : '0;

    if (item.eos) begin
      high_pending_next   = 1'b0;
      high_bits_next      = '0;
      output_stopped_next = 1'b0;
    end else begin
      high_pending_next   = set_pending;
      high_bits_next      = set_pending ? item.code_unit[9:0] : 10'd0;
      output_stopped_next = output_stopped || a_fail || b_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending   <= 1'b0;
      high_bits      <= '0;
      bytes_written  <= '0;
      output_stopped <= 1'b0;
    end else if (take) begin
      high_pending   <= high_pending_next;
      high_bits      <= high_bits_next;
      bytes_written  <= item.eos ? '0 : bytes_written_next;
      output_stopped <= output_stopped_next;
    end
  end
endmodule

FILE: rtl/u2u8_serializer.sv
`timescale 1ns / 1ps
// Result register: holds one burst and shifts it out one byte per output
// transaction. Depends on u2u8_pkg and u2u8_byte_if.
module u2u8_serializer (
  input  logic             clk,
  input  logic             rst,
  input  u2u8_pkg::burst_t burst,
  input  logic             take,
  output logic             free,
  u2u8_byte_if.source      utf8
);
  import u2u8_pkg::*;

  logic                     busy;
  logic [CountWidth-1:0]    remaining;
  logic [MaxBytes-1:0][7:0] bytes;
  logic                     has_bytes;
  logic                     eos;
  logic [LenWidth-1:0]      length;
  logic                     last;

  assign last = remaining == 3'd1;
  assign free = !busy || (utf8.ready && last);

  assign utf8.valid         = busy;
  assign utf8.out_byte      = has_bytes ? bytes[0] : 8'd0;
  assign utf8.byte_valid    = has_bytes;
  assign utf8.last_of_item  = last;
  assign utf8.string_done   = eos && last;
  assign utf8.string_length = (eos && last) ? length : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (take) begin
      busy      <= burst.count != 3'd0;
      remaining <= burst.count;
    end else if (busy && utf8.ready) begin
      busy      <= !last;
      remaining <= remaining - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bytes     <= burst.bytes;
      has_bytes <= burst.has_bytes;
      eos       <= burst.eos;
      length    <= burst.length;
    end else if (busy && utf8.ready) begin
      bytes     <= bytes >> 8;
    end
  end
endmodule
